// ===== src/wrip_pkg.sv =====
package wrip_pkg;

   localparam int MaxBackends = 8;
   localparam int WeightBits  = 16;
   localparam int IdxBits     = (MaxBackends > 1) ? $clog2(MaxBackends) : 1;
   localparam int RandBits    = 19;
   localparam int CountBits   = 4;
   localparam int CmpBits     = (WeightBits > RandBits) ? WeightBits : RandBits;
   localparam int CsrIdxBits  = 1;
   localparam int CsrDataBits = 4;

   localparam logic [CsrIdxBits-1:0] CsrBackendCount = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrMonitorValid = 1'd1;

   typedef enum logic [1:0] {
      OP_STATUS = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2
   } op_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic [MaxBackends-1:0] eligible;
      logic [RandBits-1:0]    random;
   } go_type;

   typedef struct packed {
      logic               valid;
      logic               found;
      logic [IdxBits-1:0] pick;
   } done_type;

endpackage

// ===== src/wrip_walker.sv =====
module wrip_walker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wrip_pkg::go_type                      go,
   input  logic [wrip_pkg::WeightBits-1:0]       weight,
   output logic [wrip_pkg::IdxBits-1:0]          index,
   output logic                                  busy,
   output wrip_pkg::done_type                    done
);

   localparam logic [wrip_pkg::IdxBits-1:0] LastIdx =
      wrip_pkg::IdxBits'(wrip_pkg::MaxBackends - 1);

   wrip_pkg::state_type                  state_ff, state_in;
   logic [wrip_pkg::IdxBits-1:0]         idx_ff, idx_in;
   logic [wrip_pkg::RandBits-1:0]        r_ff, r_in;
   logic [wrip_pkg::MaxBackends-1:0]     elig_ff, elig_in;
   logic [wrip_pkg::CmpBits-1:0]         w_ext, r_ext, diff;
   logic                                 hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrip_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      r_ff    <= r_in;
      elig_ff <= elig_in;
   end

   always_comb begin
      w_ext      = wrip_pkg::CmpBits'(weight);
      r_ext      = wrip_pkg::CmpBits'(r_ff);
      diff       = r_ext - w_ext;
      hit        = elig_ff[idx_ff] && ((r_ff == '0) || (w_ext >= r_ext));
      state_in   = state_ff;
      idx_in     = idx_ff;
      r_in       = r_ff;
      elig_in    = elig_ff;
      done       = '0;
      case (state_ff)
         wrip_pkg::STATE_IDLE: begin
            if (go.valid) begin
               state_in = wrip_pkg::STATE_WALK;
               idx_in   = '0;
               r_in     = go.random;
               elig_in  = go.eligible;
            end
         end
         wrip_pkg::STATE_WALK: begin
            if (hit) begin
               done.valid = 1'b1;
               done.found = 1'b1;
               done.pick  = idx_ff;
               state_in   = wrip_pkg::STATE_IDLE;
            end else begin
               if (elig_ff[idx_ff]) begin
                  r_in = wrip_pkg::RandBits'(diff);
               end
               if (idx_ff == LastIdx) begin
                  done.valid = 1'b1;
                  state_in   = wrip_pkg::STATE_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = wrip_pkg::STATE_IDLE;
         end
      endcase
   end

   assign index = idx_ff;
   assign busy  = (state_ff == wrip_pkg::STATE_WALK);

   a_go_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (!busy && go.valid) |=> busy)
      else $error("walk did not start after go");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (busy && !done.valid) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("walk index did not advance");

   a_found_eligible: assert property (@(posedge clock) disable iff (reset)
      (done.valid && done.found) |-> elig_ff[done.pick])
      else $error("picked backend is not eligible");

   a_random_falls: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy) && !$past(done.valid)) |-> (r_ff <= $past(r_ff)))
      else $error("remaining random value grew during walk");

endmodule

// ===== src/weighted_random_instance_picker.sv =====
// Status items and undefined operations answer with rsp_strobe in the cycle after acceptance.
// A pick walks the table one backend per cycle through a shared subtract-and-compare unit,
// so its word is registered when the walk ends, and busy stays high while the walk runs.
// A new item is taken only while busy is low, so status items go one per cycle while no walk runs.
// The receiver cannot stall: each result word is shown for exactly one cycle.
// Synchronous reset clears the table, sets backend_count to 1 and monitor_valid to 1.
module weighted_random_instance_picker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [2:0]                           req_backend_index,
   input  logic                                 req_backend_up,
   input  logic [wrip_pkg::WeightBits-1:0]      req_read_weight,
   input  logic [wrip_pkg::WeightBits-1:0]      req_write_weight,
   input  logic [wrip_pkg::MaxBackends-1:0]     req_clean_copy_mask,
   input  logic [wrip_pkg::MaxBackends-1:0]     req_dirty_copy_mask,
   input  logic [wrip_pkg::RandBits-1:0]        req_random_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_result_code,
   output logic [2:0]                           rsp_chosen_backend,
   output logic                                 rsp_dirty_allowed,
   input  logic                                 csr_write_enable,
   input  logic [wrip_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [wrip_pkg::CsrDataBits-1:0]     csr_write_data
);

   logic [wrip_pkg::CountBits-1:0]    count_ff, count_in;
   logic                              monitor_ff, monitor_in;
   logic [wrip_pkg::MaxBackends-1:0]  up_ff, up_in;
   logic [wrip_pkg::WeightBits-1:0]   rweight_ff [wrip_pkg::MaxBackends];
   logic [wrip_pkg::WeightBits-1:0]   rweight_in [wrip_pkg::MaxBackends];
   logic [wrip_pkg::WeightBits-1:0]   wweight_ff [wrip_pkg::MaxBackends];
   logic [wrip_pkg::WeightBits-1:0]   wweight_in [wrip_pkg::MaxBackends];
   logic                              wsel_ff, wsel_in;
   logic                              dirty_hold_ff, dirty_hold_in;
   logic                              strobe_ff, strobe_in;
   logic                              code_ff, code_in;
   logic [2:0]                        chosen_ff, chosen_in;
   logic                              dirty_ff, dirty_in;

   logic                              accept;
   wrip_pkg::op_type                  op;
   logic [wrip_pkg::MaxBackends-1:0]  active, upm, clean_m, dirty_m, elig_read;
   logic [wrip_pkg::MaxBackends-1:0]  first_only;
   logic                              dirty_ok;
   wrip_pkg::go_type                  go;
   wrip_pkg::done_type                done;
   logic [wrip_pkg::IdxBits-1:0]      walk_idx;
   logic [wrip_pkg::WeightBits-1:0]   walk_weight;

   wrip_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .weight (walk_weight),
      .index  (walk_idx),
      .busy   (busy),
      .done   (done)
   );

   assign walk_weight = wsel_ff ? wweight_ff[walk_idx] : rweight_ff[walk_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= wrip_pkg::CountBits'(1);
         monitor_ff <= 1'b1;
         up_ff      <= '0;
         strobe_ff  <= 1'b0;
         for (int i = 0; i < wrip_pkg::MaxBackends; i++) begin
            rweight_ff[i] <= '0;
            wweight_ff[i] <= '0;
         end
      end else begin
         count_ff   <= count_in;
         monitor_ff <= monitor_in;
         up_ff      <= up_in;
         strobe_ff  <= strobe_in;
         for (int i = 0; i < wrip_pkg::MaxBackends; i++) begin
            rweight_ff[i] <= rweight_in[i];
            wweight_ff[i] <= wweight_in[i];
         end
      end
      wsel_ff       <= wsel_in;
      dirty_hold_ff <= dirty_hold_in;
      code_ff       <= code_in;
      chosen_ff     <= chosen_in;
      dirty_ff      <= dirty_in;
   end

   always_comb begin
      accept = start && !busy;
      op     = wrip_pkg::op_type'(req_operation);
      for (int i = 0; i < wrip_pkg::MaxBackends; i++) begin
         active[i]     = (32'(count_ff) > i);
         first_only[i] = (i == 0);
      end
      upm       = monitor_ff ? up_ff : '1;
      clean_m   = req_clean_copy_mask & active;
      dirty_m   = req_dirty_copy_mask & active;
      dirty_ok  = ((clean_m & upm) == '0);
      elig_read = (clean_m | (dirty_ok ? dirty_m : '0)) & upm;

      count_in   = count_ff;
      monitor_in = monitor_ff;
      if (csr_write_enable) begin
         case (csr_index)
            wrip_pkg::CsrBackendCount: count_in   = csr_write_data[wrip_pkg::CountBits-1:0];
            wrip_pkg::CsrMonitorValid: monitor_in = csr_write_data[0];
            default: ;
         endcase
      end

      up_in = up_ff;
      for (int i = 0; i < wrip_pkg::MaxBackends; i++) begin
         rweight_in[i] = rweight_ff[i];
         wweight_in[i] = wweight_ff[i];
      end

      go            = '0;
      wsel_in       = wsel_ff;
      dirty_hold_in = dirty_hold_ff;
      strobe_in     = 1'b0;
      code_in       = code_ff;
      chosen_in     = chosen_ff;
      dirty_in      = dirty_ff;

      if (accept) begin
         case (op)
            wrip_pkg::OP_STATUS: begin
               for (int i = 0; i < wrip_pkg::MaxBackends; i++) begin
                  if (32'(req_backend_index) == i) begin
                     up_in[i]      = req_backend_up;
                     rweight_in[i] = req_read_weight;
                     wweight_in[i] = req_write_weight;
                  end
               end
               strobe_in = 1'b1;
               code_in   = 1'b0;
               chosen_in = '0;
               dirty_in  = 1'b0;
            end
            wrip_pkg::OP_READ: begin
               go.valid      = 1'b1;
               go.eligible   = elig_read;
               go.random     = monitor_ff ? req_random_value : '0;
               wsel_in       = 1'b0;
               dirty_hold_in = dirty_ok;
            end
            wrip_pkg::OP_WRITE: begin
               go.valid      = 1'b1;
               go.eligible   = monitor_ff ? (up_ff & active) : (first_only & active);
               go.random     = monitor_ff ? req_random_value : '0;
               wsel_in       = 1'b1;
               dirty_hold_in = 1'b0;
            end
            default: begin
               strobe_in = 1'b1;
               code_in   = 1'b1;
               chosen_in = '0;
               dirty_in  = 1'b0;
            end
         endcase
      end

      if (done.valid) begin
         strobe_in = 1'b1;
         code_in   = !done.found;
         chosen_in = done.found ? 3'(done.pick) : '0;
         dirty_in  = dirty_hold_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_result_code    = code_ff;
   assign rsp_chosen_backend = chosen_ff;
   assign rsp_dirty_allowed  = dirty_ff;

endmodule

// ===== tb/tb_weighted_random_instance_picker.sv =====
`timescale 1ns / 1ps

module tb_weighted_random_instance_picker;
   import wrip_pkg::*;

   localparam logic [1:0] OpUndefined = 2'd3;
   localparam logic       ResOk       = 1'b0;
   localparam logic       ResNotFound = 1'b1;
   localparam int         RandomItems = 1350;

   typedef struct packed {
      logic [1:0]             operation;
      logic [2:0]             backend_index;
      logic                   backend_up;
      logic [WeightBits-1:0]  read_weight;
      logic [WeightBits-1:0]  write_weight;
      logic [MaxBackends-1:0] clean_mask;
      logic [MaxBackends-1:0] dirty_mask;
      logic [RandBits-1:0]    random_value;
   } pick_request_type;

   typedef struct packed {
      logic       result_code;
      logic [2:0] chosen_backend;
      logic       dirty_allowed;
   } pick_answer_type;

   class pick_scoreboard;
      logic [CountBits-1:0]   count_setting;
      logic                   monitor_on;
      logic [MaxBackends-1:0] up_mask;
      logic [WeightBits-1:0]  read_weights[MaxBackends];
      logic [WeightBits-1:0]  write_weights[MaxBackends];
      pick_answer_type        expected_answers[$];
      int errors, status_count, read_count, write_count, undefined_count;
      int found_count, not_found_count, dirty_reads, settings_applied;

      function new();
         count_setting = 4'd1;
         monitor_on    = 1'b1;
         up_mask       = '0;
         for (int i = 0; i < MaxBackends; i++) begin
            read_weights[i]  = '0;
            write_weights[i] = '0;
         end
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void apply_setting(input logic [CsrIdxBits-1:0] index,
                                  input logic [CsrDataBits-1:0] data);
         if (index == CsrBackendCount) begin
            count_setting = data;
         end else begin
            monitor_on = data[0];
         end
         settings_applied++;
      endfunction

      function logic [MaxBackends-1:0] backends_in_use();
         logic [MaxBackends-1:0] in_use;
         in_use = '0;
         for (int i = 0; i < MaxBackends; i++) begin
            if (i < count_setting) in_use[i] = 1'b1;
         end
         return in_use;
      endfunction

      function int unsigned eligible_weight_sum(input bit for_read);
         int unsigned total;
         logic [MaxBackends-1:0] in_use;
         total  = 0;
         in_use = backends_in_use();
         for (int i = 0; i < MaxBackends; i++) begin
            if (up_mask[i] && in_use[i]) total += for_read ? read_weights[i] : write_weights[i];
         end
         return total;
      endfunction

      function pick_answer_type predict_answer(input pick_request_type req);
         pick_answer_type ans;
         logic [MaxBackends-1:0] in_use, usable, eligible;
         int unsigned remaining, w;
         bit dirty_ok, found;
         ans      = '0;
         in_use   = backends_in_use();
         dirty_ok = 1'b0;
         found    = 1'b0;
         if (req.operation == OP_STATUS) begin
            status_count++;
            up_mask[req.backend_index]       = req.backend_up;
            read_weights[req.backend_index]  = req.read_weight;
            write_weights[req.backend_index] = req.write_weight;
            return ans;
         end
         if (req.operation == OpUndefined) begin
            undefined_count++;
            ans.result_code = ResNotFound;
            return ans;
         end
         usable = monitor_on ? up_mask : '1;
         if (req.operation == OP_READ) begin
            read_count++;
            dirty_ok = (req.clean_mask & usable & in_use) == '0;
            eligible = (req.clean_mask | (dirty_ok ? req.dirty_mask : '0)) & usable & in_use;
         end else begin
            write_count++;
            eligible = usable & in_use;
         end
         if (monitor_on) begin
            remaining = req.random_value;
            for (int i = 0; i < MaxBackends; i++) begin
               if (!found && eligible[i]) begin
                  w = (req.operation == OP_READ) ? read_weights[i] : write_weights[i];
                  if (remaining == 0 || w >= remaining) begin
                     found              = 1'b1;
                     ans.chosen_backend = i[2:0];
                  end else begin
                     remaining -= w;
                  end
               end
            end
         end else if (req.operation == OP_READ) begin
            for (int i = 0; i < MaxBackends; i++) begin
               if (!found && eligible[i]) begin
                  found              = 1'b1;
                  ans.chosen_backend = i[2:0];
               end
            end
         end else begin
            found = in_use != '0;
         end
         ans.result_code   = found ? ResOk : ResNotFound;
         ans.dirty_allowed = (req.operation == OP_READ) && dirty_ok;
         if (found) found_count++;
         else not_found_count++;
         if (ans.dirty_allowed) dirty_reads++;
         return ans;
      endfunction

      function void note_request(input pick_request_type req);
         expected_answers.push_back(predict_answer(req));
      endfunction

      task check_answer(input logic code, input logic [2:0] backend, input logic dirty);
         pick_answer_type exp;
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected word code=%0b backend=%0d dirty=%0b",
                                      code, backend, dirty));
            return;
         end
         exp = expected_answers.pop_front();
         if (code !== exp.result_code || backend !== exp.chosen_backend
             || dirty !== exp.dirty_allowed) begin
            report_mismatch($sformatf("got code=%0b backend=%0d dirty=%0b, want %0b/%0d/%0b",
                                      code, backend, dirty, exp.result_code,
                                      exp.chosen_backend, exp.dirty_allowed));
         end
      endtask

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_operation = '0;
   logic [2:0]             req_backend_index = '0;
   logic                   req_backend_up = 1'b0;
   logic [WeightBits-1:0]  req_read_weight = '0;
   logic [WeightBits-1:0]  req_write_weight = '0;
   logic [MaxBackends-1:0] req_clean_copy_mask = '0;
   logic [MaxBackends-1:0] req_dirty_copy_mask = '0;
   logic [RandBits-1:0]    req_random_value = '0;
   logic                   rsp_strobe;
   logic                   rsp_result_code;
   logic [2:0]             rsp_chosen_backend;
   logic                   rsp_dirty_allowed;
   logic                   csr_write_enable = 1'b0;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_write_data = '0;

   pick_scoreboard sb = new();

   weighted_random_instance_picker i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_backend_index   (req_backend_index),
      .req_backend_up      (req_backend_up),
      .req_read_weight     (req_read_weight),
      .req_write_weight    (req_write_weight),
      .req_clean_copy_mask (req_clean_copy_mask),
      .req_dirty_copy_mask (req_dirty_copy_mask),
      .req_random_value    (req_random_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_code     (rsp_result_code),
      .rsp_chosen_backend  (rsp_chosen_backend),
      .rsp_dirty_allowed   (rsp_dirty_allowed),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_answer(rsp_result_code, rsp_chosen_backend, rsp_dirty_allowed);
      end
   end

   task automatic issue(input logic [1:0] op, input logic [2:0] index, input logic up,
                        input logic [WeightBits-1:0] rw, input logic [WeightBits-1:0] ww,
                        input logic [MaxBackends-1:0] clean,
                        input logic [MaxBackends-1:0] dirty,
                        input logic [RandBits-1:0] rnd);
      pick_request_type req;
      req = '{op, index, up, rw, ww, clean, dirty, rnd};
      req_operation       <= op;
      req_backend_index   <= index;
      req_backend_up      <= up;
      req_read_weight     <= rw;
      req_write_weight    <= ww;
      req_clean_copy_mask <= clean;
      req_dirty_copy_mask <= dirty;
      req_random_value    <= rnd;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(req);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      for (int k = 0; k < 2000 && sb.pending() != 0; k++) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CsrDataBits-1:0] count_data,
                                 input logic [CsrDataBits-1:0] valid_data);
      bit monitor_first;
      monitor_first    = $urandom_range(0, 1);
      csr_write_enable <= 1'b1;
      csr_index        <= monitor_first ? CsrMonitorValid : CsrBackendCount;
      csr_write_data   <= monitor_first ? valid_data : count_data;
      @(posedge clock);
      csr_index        <= monitor_first ? CsrBackendCount : CsrMonitorValid;
      csr_write_data   <= monitor_first ? count_data : valid_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.apply_setting(CsrBackendCount, count_data);
      sb.apply_setting(CsrMonitorValid, valid_data);
   endtask

   function automatic logic [WeightBits-1:0] random_weight();
      case ($urandom_range(0, 9))
         0, 1:       return '0;
         2, 3, 4, 5: return WeightBits'($urandom_range(1, 12));
         default:    return WeightBits'($urandom);
      endcase
   endfunction

   task automatic issue_random();
      logic [1:0]             op;
      logic [MaxBackends-1:0] clean;
      logic [RandBits-1:0]    rnd;
      int unsigned            total;
      int                     sel;
      sel = $urandom_range(0, 19);
      if (sel < 6) op = OP_STATUS;
      else if (sel < 13) op = OP_READ;
      else if (sel < 19) op = OP_WRITE;
      else op = OpUndefined;
      clean = ($urandom_range(0, 3) == 0) ? '0 : MaxBackends'($urandom);
      if ($urandom_range(0, 2) == 0) clean &= MaxBackends'($urandom);
      total = sb.eligible_weight_sum(op == OP_READ);
      case ($urandom_range(0, 9))
         0:       rnd = '0;
         1, 2, 3: rnd = RandBits'($urandom);
         4:       rnd = '1;
         default: rnd = RandBits'($urandom_range(1, total + 2));
      endcase
      issue(op, 3'($urandom), $urandom_range(0, 3) != 0, random_weight(), random_weight(),
            clean, MaxBackends'($urandom), rnd);
   endtask

   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int issued, phase_len, burst_left, gap;
      logic [CsrDataBits-1:0] count_data;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(4'd8, 4'd1);
      issue(OP_STATUS, 3'd0, 1'b1, 16'hFFFF, 16'h0000, 8'h00, 8'h00, '0);
      issue(OP_STATUS, 3'd7, 1'b1, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, '1);
      issue(OP_STATUS, 3'd3, 1'b1, 16'd5, 16'd5, 8'h00, 8'h00, '0);
      issue(OP_STATUS, 3'd5, 1'b0, 16'd100, 16'd100, 8'h00, 8'h00, '0);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'hFF, 8'h00, 19'd0);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'hFF, 8'h00, 19'd65535);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'hFF, 8'h00, 19'd65540);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'hFF, 8'h00, '1);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h80, 8'h00, 19'd1);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h80, 8'h00, 19'd0);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h20, 8'h89, 19'd0);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd0);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd0);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd1);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, '1);
      issue(OpUndefined, '1, 1'b1, '1, '1, '1, '1, '1);
      wait_idle();
      apply_settings(4'd0, 4'd1);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'hFF, 8'hFF, 19'd0);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd0);
      wait_idle();
      apply_settings(4'd15, 4'd1);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h80, 8'h00, 19'd0);
      wait_idle();
      apply_settings(4'd15, 4'hE);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h00, 8'h40, 19'd7);
      issue(OP_READ, 3'd0, 1'b0, '0, '0, 8'h10, 8'h01, 19'd7);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd9);
      wait_idle();
      apply_settings(4'd0, 4'd2);
      issue(OP_WRITE, 3'd0, 1'b0, '0, '0, 8'h00, 8'h00, 19'd0);
      wait_idle();

      issued     = 0;
      burst_left = $urandom_range(1, 24);
      while (issued < RandomItems) begin
         case ($urandom_range(0, 9))
            0:       count_data = 4'd0;
            1:       count_data = 4'($urandom_range(9, 15));
            2:       count_data = 4'd8;
            default: count_data = 4'($urandom_range(1, 8));
         endcase
         apply_settings(count_data,
                        {3'($urandom), $urandom_range(0, 4) != 0});
         phase_len = $urandom_range(30, 120);
         for (int j = 0; j < phase_len; j++) begin
            issue_random();
            issued++;
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap != 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end else begin
               burst_left--;
            end
         end
         wait_idle();
      end

      repeat (12) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
      end
      $display("Covered %0d status, %0d read, %0d write, %0d undefined words, %0d register writes.",
               sb.status_count, sb.read_count, sb.write_count, sb.undefined_count,
               sb.settings_applied);
      $display("Picks found %0d, not found %0d, reads with dirty copies allowed %0d.",
               sb.found_count, sb.not_found_count, sb.dirty_reads);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
